[hdl/lfpid_pkg.sv]
package lfpid_pkg;

   // Fixed field widths
   localparam int POS_W   = 13;
   localparam int ERR_W   = 14;
   localparam int DERIV_W = 15;
   localparam int GAIN_W  = 16;
   localparam int SPEED_W = 8;
   localparam int CORR_W  = 16;
   localparam int MIX_W   = CORR_W + 2;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SPEED  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LIMIT = 3'd4;

   // Register values after reset (gains in Q8.8: about 0.1 and 0.5)
   localparam logic [GAIN_W-1:0]  RST_GAIN_P      = 16'd26;
   localparam logic [GAIN_W-1:0]  RST_GAIN_I      = 16'd0;
   localparam logic [GAIN_W-1:0]  RST_GAIN_D      = 16'd128;
   localparam logic [SPEED_W-1:0] RST_BASE_SPEED  = 8'd150;
   localparam logic [SPEED_W-1:0] RST_SPEED_LIMIT = 8'd255;

   // Line position that means the robot is centred on the line
   localparam logic signed [ERR_W-1:0] CENTRE_POS = 14'sd3500;

   typedef logic [SPEED_W-1:0]        speed_type;
   typedef logic signed [CORR_W-1:0]  corr_type;

endpackage

[hdl/lfpid_mix.sv]
module lfpid_mix
   import lfpid_pkg::*;
(
   input  speed_type base_speed,
   input  speed_type speed_limit,
   input  corr_type  corr,
   output speed_type left_speed,
   output speed_type right_speed
);

   logic signed [MIX_W-1:0] base_s;
   logic signed [MIX_W-1:0] corr_s;
   logic signed [MIX_W-1:0] limit_s;
   logic signed [MIX_W-1:0] left_raw;
   logic signed [MIX_W-1:0] right_raw;

   assign base_s    = $signed({{(MIX_W-SPEED_W){1'b0}}, base_speed});
   assign limit_s   = $signed({{(MIX_W-SPEED_W){1'b0}}, speed_limit});
   assign corr_s    = MIX_W'(corr);
   assign left_raw  = base_s - corr_s;
   assign right_raw = base_s + corr_s;

   // Each wheel is clamped to zero below and to the speed limit above.
   always_comb begin
      if (left_raw < 0) begin
         left_speed = '0;
      end else if (left_raw > limit_s) begin
         left_speed = speed_limit;
      end else begin
         left_speed = left_raw[SPEED_W-1:0];
      end
   end

   always_comb begin
      if (right_raw < 0) begin
         right_speed = '0;
      end else if (right_raw > limit_s) begin
         right_speed = speed_limit;
      end else begin
         right_speed = right_raw[SPEED_W-1:0];
      end
   end

endmodule

[hdl/line_follow_pid_differential_drive_top.sv]
// PID line-follower controller for a differential-drive robot. Each request
// transaction carries one line position (3500 is centre); the controller forms
// the error, its saturating running sum and its change since the previous
// sample, weights the three with the unsigned Q8.8 gains, floors the sum by
// GAIN_FRAC_BITS, saturates it to a 16-bit signed correction and returns one
// response transaction with left = base - correction and right = base +
// correction, each clamped to 0..the speed limit. The datapath is four register
// stages deep (input/state register, product register, correction register,
// result register), and one transaction per cycle is sustained whenever the
// response side keeps rsp_ready high. Each stage is held only while the stage
// after it is full and stalled, so a waiting response never blocks new
// requests until the whole pipeline has filled. The integrator and the
// previous error are updated at the moment a request is accepted. The
// configuration registers are written through the csr_ port and should only
// be changed while no transaction is in flight.
module line_follow_pid_differential_drive_top
   import lfpid_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = 8,
   parameter int SUM_BITS       = 24
)
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [POS_W-1:0]      req_position,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [SPEED_W-1:0]    rsp_left_speed,
   output logic [SPEED_W-1:0]    rsp_right_speed
);

   // Product widths: unsigned gain (made signed with a leading zero) times
   // a signed operand.
   localparam int PROD_P_W = GAIN_W + 1 + ERR_W;
   localparam int PROD_I_W = GAIN_W + 1 + SUM_BITS;
   localparam int PROD_D_W = GAIN_W + 1 + DERIV_W;
   localparam int ACC_W    = PROD_I_W + 2;

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic [GAIN_W-1:0] gain_p_ff;
   logic [GAIN_W-1:0] gain_i_ff;
   logic [GAIN_W-1:0] gain_d_ff;
   speed_type         base_speed_ff;
   speed_type         speed_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff      <= RST_GAIN_P;
         gain_i_ff      <= RST_GAIN_I;
         gain_d_ff      <= RST_GAIN_D;
         base_speed_ff  <= RST_BASE_SPEED;
         speed_limit_ff <= RST_SPEED_LIMIT;
      end else if (csr_write_en) begin
         // Writes to an index beyond the register list are dropped.
         case (csr_index)
            CSR_GAIN_P:      gain_p_ff      <= csr_wdata;
            CSR_GAIN_I:      gain_i_ff      <= csr_wdata;
            CSR_GAIN_D:      gain_d_ff      <= csr_wdata;
            CSR_BASE_SPEED:  base_speed_ff  <= csr_wdata[SPEED_W-1:0];
            CSR_SPEED_LIMIT: speed_limit_ff <= csr_wdata[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Stage handshakes. A stage may load when it is empty or when its
   // contents move on in the same cycle.
   // ---------------------------------------------------------------------
   logic s1_valid_ff;
   logic s2_valid_ff;
   logic s3_valid_ff;
   logic rsp_valid_ff;
   logic out_ready;
   logic s3_ready;
   logic s2_ready;
   logic req_accept;

   assign out_ready  = !rsp_valid_ff || rsp_ready;
   assign s3_ready   = !s3_valid_ff || out_ready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign req_ready  = !s1_valid_ff || s2_ready;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_ready) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: error, integrator and derivative. The controller state moves
   // on with every accepted transaction.
   // ---------------------------------------------------------------------
   logic signed [ERR_W-1:0]    prev_err_ff;
   logic signed [SUM_BITS-1:0] err_sum_ff;
   logic signed [ERR_W-1:0]    err_in;
   logic signed [SUM_BITS:0]   sum_wide;
   logic signed [SUM_BITS-1:0] sum_in;
   logic signed [DERIV_W-1:0]  deriv_in;

   logic signed [ERR_W-1:0]    s1_err_ff;
   logic signed [SUM_BITS-1:0] s1_sum_ff;
   logic signed [DERIV_W-1:0]  s1_deriv_ff;

   assign err_in   = CENTRE_POS - $signed({1'b0, req_position});
   assign sum_wide = $signed({err_sum_ff[SUM_BITS-1], err_sum_ff}) + (SUM_BITS+1)'(err_in);
   assign deriv_in = DERIV_W'(err_in) - DERIV_W'(prev_err_ff);

   // The two top bits of the widened sum disagree only on overflow; the
   // integrator then sticks at the limit on the side of the sign.
   always_comb begin
      if (sum_wide[SUM_BITS] != sum_wide[SUM_BITS-1]) begin
         sum_in = sum_wide[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}}
                                     : {1'b0, {(SUM_BITS-1){1'b1}}};
      end else begin
         sum_in = sum_wide[SUM_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff <= '0;
         err_sum_ff  <= '0;
      end else if (req_accept) begin
         prev_err_ff <= err_in;
         err_sum_ff  <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_err_ff   <= err_in;
         s1_sum_ff   <= sum_in;
         s1_deriv_ff <= deriv_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: the three gain products, side by side.
   // ---------------------------------------------------------------------
   logic signed [GAIN_W:0]     gp_s;
   logic signed [GAIN_W:0]     gi_s;
   logic signed [GAIN_W:0]     gd_s;
   logic signed [PROD_P_W-1:0] prod_p_in;
   logic signed [PROD_I_W-1:0] prod_i_in;
   logic signed [PROD_D_W-1:0] prod_d_in;
   logic signed [PROD_P_W-1:0] s2_prod_p_ff;
   logic signed [PROD_I_W-1:0] s2_prod_i_ff;
   logic signed [PROD_D_W-1:0] s2_prod_d_ff;

   assign gp_s      = $signed({1'b0, gain_p_ff});
   assign gi_s      = $signed({1'b0, gain_i_ff});
   assign gd_s      = $signed({1'b0, gain_d_ff});
   assign prod_p_in = PROD_P_W'(gp_s) * PROD_P_W'(s1_err_ff);
   assign prod_i_in = PROD_I_W'(gi_s) * PROD_I_W'(s1_sum_ff);
   assign prod_d_in = PROD_D_W'(gd_s) * PROD_D_W'(s1_deriv_ff);

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s2_ready) begin
         s2_prod_p_ff <= prod_p_in;
         s2_prod_i_ff <= prod_i_in;
         s2_prod_d_ff <= prod_d_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3: sum, floor by the gain fraction (arithmetic shift), then
   // saturate to the 16-bit signed correction.
   // ---------------------------------------------------------------------
   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] acc_shift;
   corr_type                corr_in;
   corr_type                s3_corr_ff;
   logic [ACC_W-CORR_W:0]   acc_top;

   assign acc       = ACC_W'(s2_prod_p_ff) + ACC_W'(s2_prod_i_ff) + ACC_W'(s2_prod_d_ff);
   assign acc_shift = acc >>> GAIN_FRAC_BITS;
   assign acc_top   = acc_shift[ACC_W-1:CORR_W-1];

   always_comb begin
      if ((&acc_top) || !(|acc_top)) begin
         corr_in = acc_shift[CORR_W-1:0];
      end else begin
         corr_in = acc_shift[ACC_W-1] ? {1'b1, {(CORR_W-1){1'b0}}}
                                      : {1'b0, {(CORR_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff && s3_ready) begin
         s3_corr_ff <= corr_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 4: wheel mix and clamp into the response register.
   // ---------------------------------------------------------------------
   speed_type left_in;
   speed_type right_in;
   speed_type left_ff;
   speed_type right_ff;

   lfpid_mix u_mix (
      .base_speed  (base_speed_ff),
      .speed_limit (speed_limit_ff),
      .corr        (s3_corr_ff),
      .left_speed  (left_in),
      .right_speed (right_in)
   );

   always_ff @(posedge clock) begin
      if (s3_valid_ff && out_ready) begin
         left_ff  <= left_in;
         right_ff <= right_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_speed  = left_ff;
   assign rsp_right_speed = right_ff;

endmodule

[hdl/lfpid_checker.sv]
module lfpid_checker
   import lfpid_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [SPEED_W-1:0] rsp_left_speed,
   input logic [SPEED_W-1:0] rsp_right_speed
);

   // A stalled response keeps its speeds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_left_speed)
                                  && $stable(rsp_right_speed))
      else $error("response changed or dropped while stalled");

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

   // With the response side free, the pipeline always has room for a request.
   a_req_room: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request stalled although the response side is free");

   // No response appears straight after reset.
   a_no_early_rsp: assert property (@(posedge clock)
      $past(reset) |=> !rsp_valid)
      else $error("response appeared too early after reset");

endmodule

bind line_follow_pid_differential_drive_top lfpid_checker u_checker (.*);

[dv/lfpid_wheel_speed_checker.sv]
module lfpid_wheel_speed_checker
   import lfpid_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = 8,
   parameter int SUM_BITS       = 24
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic [POS_W-1:0]      req_position,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [SPEED_W-1:0]    rsp_left_speed,
   input  logic [SPEED_W-1:0]    rsp_right_speed,
   output int                    mismatch_count,
   output int                    speeds_pending
);

   typedef struct packed {
      speed_type left;
      speed_type right;
   } wheel_pair_type;

   wheel_pair_type             due_speeds_q [$];
   wheel_pair_type             oldest_due;

   logic [GAIN_W-1:0]          kp;
   logic [GAIN_W-1:0]          ki;
   logic [GAIN_W-1:0]          kd;
   speed_type                  base_spd;
   speed_type                  ceiling_spd;
   logic signed [ERR_W-1:0]    last_error;
   logic signed [SUM_BITS-1:0] error_integral;

   function automatic longint clip(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   // Takes one position sample and moves the integrator and the derivative memory on.
   function automatic wheel_pair_type steer_wheels(input logic [POS_W-1:0] position);
      longint         integral_max;
      longint         err;
      longint         integral;
      longint         change;
      longint         weighted;
      longint         correction;
      wheel_pair_type speeds;
      integral_max = (longint'(1) <<< (SUM_BITS - 1)) - 1;
      err          = longint'(CENTRE_POS) - longint'(position);
      integral     = clip(longint'(error_integral) + err, -integral_max - 1, integral_max);
      change       = err - longint'(last_error);
      weighted     = longint'(kp) * err + longint'(ki) * integral + longint'(kd) * change;
      // An arithmetic shift of a signed value rounds towards minus infinity.
      correction   = clip(weighted >>> GAIN_FRAC_BITS, -32768, 32767);
      speeds.left  = SPEED_W'(clip(longint'(base_spd) - correction, 0, longint'(ceiling_spd)));
      speeds.right = SPEED_W'(clip(longint'(base_spd) + correction, 0, longint'(ceiling_spd)));
      error_integral = integral[SUM_BITS-1:0];
      last_error     = err[ERR_W-1:0];
      return speeds;
   endfunction

   function automatic void note_mismatch(input string what, input logic [SPEED_W-1:0] want,
                                         input logic [SPEED_W-1:0] got);
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         due_speeds_q.delete();
         kp             = RST_GAIN_P;
         ki             = RST_GAIN_I;
         kd             = RST_GAIN_D;
         base_spd       = RST_BASE_SPEED;
         ceiling_spd    = RST_SPEED_LIMIT;
         last_error     = '0;
         error_integral = '0;
         mismatch_count = 0;
      end else begin
         // The response side is handled first: no response may leave in the
         // same cycle as the request that causes it.
         if (rsp_valid && rsp_ready) begin
            if (due_speeds_q.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected response, expected none, got left %0d right %0d",
                        $time, rsp_left_speed, rsp_right_speed);
            end else begin
               oldest_due = due_speeds_q.pop_front();
               if (rsp_left_speed !== oldest_due.left) begin
                  note_mismatch("left_speed", oldest_due.left, rsp_left_speed);
               end
               if (rsp_right_speed !== oldest_due.right) begin
                  note_mismatch("right_speed", oldest_due.right, rsp_right_speed);
               end
            end
         end
         if (req_valid && req_ready) begin
            due_speeds_q.push_back(steer_wheels(req_position));
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_GAIN_P:      kp          = csr_wdata[GAIN_W-1:0];
               CSR_GAIN_I:      ki          = csr_wdata[GAIN_W-1:0];
               CSR_GAIN_D:      kd          = csr_wdata[GAIN_W-1:0];
               CSR_BASE_SPEED:  base_spd    = csr_wdata[SPEED_W-1:0];
               CSR_SPEED_LIMIT: ceiling_spd = csr_wdata[SPEED_W-1:0];
               default: ;
            endcase
         end
      end
      speeds_pending = due_speeds_q.size();
   end

endmodule

[dv/line_follow_pid_differential_drive_top_tb.sv]
module line_follow_pid_differential_drive_top_tb;
   import lfpid_pkg::*;

   localparam int GAIN_FRAC_BITS = 8;
   localparam int SUM_BITS       = 24;

   // Stimulus shape. The random phases run under different controller
   // settings; the integral phase afterwards swings the running sum far to
   // one side, across to the other and back towards zero.
   localparam int ITEMS_PER_PHASE = 120;
   localparam int RANDOM_PHASES   = 11;
   localparam int IDLE_PCT        = 31;
   localparam int HOLD_PHASE      = 4;
   localparam int QUIET_PHASE     = 7;
   localparam int HOLD_CYCLES     = 300;
   localparam int POS_LEGAL_MAX   = 7000;
   localparam int POS_ALL_MAX     = 2**POS_W - 1;
   localparam int WINDUP_BAND     = 127;
   localparam int WINDUP_RISE     = 120;
   localparam int WINDUP_FALL     = 140;
   localparam int WINDUP_RECOVER  = 50;
   localparam int WINDUP_BASE     = 128;
   localparam int UNITY_GAIN      = 2**GAIN_FRAC_BITS;

   // Waiting limits: the drain limit covers the long response hold-off, the
   // settle time covers the four register stages with room to spare.
   localparam int DRAIN_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 12;
   localparam int RUN_LIMIT       = 4_000_000;

   logic                  clock;
   logic                  reset           = 1'b1;
   logic                  csr_write_en    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index       = '0;
   logic [CSR_DATA_W-1:0] csr_wdata       = '0;
   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic [POS_W-1:0]      req_position    = '0;
   logic                  rsp_valid;
   logic                  rsp_ready       = 1'b0;
   logic [SPEED_W-1:0]    rsp_left_speed;
   logic [SPEED_W-1:0]    rsp_right_speed;

   int                    mismatch_count;
   int                    speeds_pending;

   // Shared between the stimulus process and the response-side process.
   int                    idle_pct = IDLE_PCT;
   int                    phase_no = 0;

   // Centred, both ends of the legal range, positions beyond the legal range
   // (up to the all-ones code), neighbours of the centre and alternating bit
   // patterns. Opening on the centre checks the reset state of the
   // derivative memory and the integrator.
   int directed_positions [20] = '{3500, 3500, 0, 0, 7000, 7000, 3500, 8191, 7001, 8191,
                                   1, 6999, 3499, 3501, 4096, 2047, 5461, 2730, 8190, 3500};

   line_follow_pid_differential_drive_top #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .SUM_BITS       (SUM_BITS)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_speed  (rsp_left_speed),
      .rsp_right_speed (rsp_right_speed)
   );

   lfpid_wheel_speed_checker #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .SUM_BITS       (SUM_BITS)
   ) u_wheel_check (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_left_speed  (rsp_left_speed),
      .rsp_right_speed (rsp_right_speed),
      .mismatch_count  (mismatch_count),
      .speeds_pending  (speeds_pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Offers one position transaction, after a random number of idle cycles,
   // and returns at the clock edge on which it is accepted. A transaction
   // that follows straight on keeps valid high without lowering it first.
   task automatic send_position(input logic [POS_W-1:0] pos);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_position <= pos;
      do @(posedge clock); while (!req_ready);
   endtask

   // Writes all five registers back to back. A write to an index beyond the
   // register map goes first; it must leave every setting untouched. The
   // speed registers carry random upper bits that the block must ignore.
   task automatic program_controller(input logic [GAIN_W-1:0] gp, input logic [GAIN_W-1:0] gi,
                                     input logic [GAIN_W-1:0] gd, input speed_type base,
                                     input speed_type ceiling);
      logic [CSR_IDX_W-1:0] spare_index;
      spare_index  = CSR_IDX_W'($urandom_range(2**CSR_IDX_W - 1, int'(CSR_SPEED_LIMIT) + 1));
      csr_write_en <= 1'b1;
      csr_index    <= spare_index;
      csr_wdata    <= CSR_DATA_W'($urandom());
      @(posedge clock);
      csr_index    <= CSR_GAIN_P;
      csr_wdata    <= gp;
      @(posedge clock);
      csr_index    <= CSR_GAIN_I;
      csr_wdata    <= gi;
      @(posedge clock);
      csr_index    <= CSR_GAIN_D;
      csr_wdata    <= gd;
      @(posedge clock);
      csr_index    <= CSR_BASE_SPEED;
      csr_wdata    <= {SPEED_W'($urandom()), base};
      @(posedge clock);
      csr_index    <= CSR_SPEED_LIMIT;
      csr_wdata    <= {SPEED_W'($urandom()), ceiling};
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Stops offering and waits until every outstanding response has come
   // back, then lets the pipeline settle before any register is touched.
   task automatic drain_pipeline();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      @(posedge clock);
      while (speeds_pending != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Mostly modest gains, so that the wheel speeds are not pinned at their
   // limits all the time; now and then the full 16-bit range.
   function automatic logic [GAIN_W-1:0] pick_gain(input bit wide);
      return wide ? GAIN_W'($urandom()) : GAIN_W'($urandom_range(600));
   endfunction

   // Most samples follow a smooth track, as a robot drifting across the line
   // would produce, so that the derivative stays small and the correction
   // lands in the range where it is visible on the wheels. The rest are
   // jumps across the legal range, positions beyond it, near-centre samples
   // and the end codes.
   function automatic logic [POS_W-1:0] next_track_position(input logic [POS_W-1:0] now);
      int stepped;
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: begin
            stepped = int'(now) + int'($urandom_range(400)) - 200;
            if (stepped < 0) stepped = 0;
            if (stepped > POS_LEGAL_MAX) stepped = POS_LEGAL_MAX;
            return POS_W'(stepped);
         end
         6:       return POS_W'($urandom_range(POS_LEGAL_MAX));
         7:       return POS_W'($urandom_range(POS_ALL_MAX, POS_LEGAL_MAX + 1));
         8:       return POS_W'($urandom_range(int'(CENTRE_POS) + 8, int'(CENTRE_POS) - 8));
         default: begin
            case ($urandom_range(2))
               0:       return '0;
               1:       return POS_W'(POS_LEGAL_MAX);
               default: return POS_W'(POS_ALL_MAX);
            endcase
         end
      endcase
   endfunction

   // The response side stalls at random, except in the quiet phase. Once, at
   // the start of the hold phase, it refuses responses for a long stretch
   // while the sender keeps offering, so that the pipeline fills and the
   // request side has to stall too.
   initial begin
      int hold_left;
      bit hold_done;
      hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (phase_no == HOLD_PHASE && !hold_done) begin
            hold_done = 1'b1;
            for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--) begin
               rsp_ready <= 1'b0;
               @(posedge clock);
            end
         end else begin
            rsp_ready <= ($urandom_range(99) >= idle_pct);
            @(posedge clock);
         end
      end
   end

   initial begin
      logic [POS_W-1:0] track_pos;
      track_pos = CENTRE_POS[POS_W-1:0];
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed samples under the settings that reset leaves behind.
      foreach (directed_positions[i]) begin
         send_position(POS_W'(directed_positions[i]));
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_pipeline();
         phase_no = phase;
         idle_pct = (phase == QUIET_PHASE) ? 0 : IDLE_PCT;
         case (phase)
            // Phase 0 keeps the reset settings.
            0: ;
            1: program_controller(pick_gain(0), pick_gain(0), pick_gain(0),
                                  SPEED_W'($urandom_range(255)), '1);
            // Every gain and speed at its top.
            2: program_controller('1, '1, '1, '1, '1);
            // Everything at zero: both wheels must stop.
            3: program_controller('0, '0, '0, '0, '0);
            // Base speed above the ceiling; this is also the phase in which
            // the response side holds off.
            HOLD_PHASE: program_controller(pick_gain(0), '0, pick_gain(0),
                                           SPEED_W'($urandom_range(255, 200)),
                                           SPEED_W'($urandom_range(150)));
            // A ceiling of zero forces both wheels to zero whatever the base.
            5: program_controller(pick_gain(0), pick_gain(0), pick_gain(0),
                                  SPEED_W'($urandom()), '0);
            // Pure proportional control at unity gain, where the correction
            // passes to the wheels almost unclamped near the centre.
            6: program_controller(GAIN_W'(UNITY_GAIN), '0, '0, SPEED_W'(WINDUP_BASE), '1);
            QUIET_PHASE: program_controller(pick_gain(0), pick_gain(0), pick_gain(0),
                                            SPEED_W'($urandom_range(200, 100)), '1);
            default: program_controller(pick_gain($urandom_range(3) == 0),
                                        pick_gain($urandom_range(3) == 0),
                                        pick_gain($urandom_range(3) == 0),
                                        SPEED_W'($urandom()), SPEED_W'($urandom()));
         endcase
         repeat (ITEMS_PER_PHASE) begin
            track_pos = next_track_position(track_pos);
            send_position(track_pos);
         end
      end

      // Integral-only control. With a unit integral gain the correction is
      // the running sum scaled down by the fractional bits, so the wheels
      // follow the sum whenever it is near zero. The sum is driven far to the
      // positive side, across to the negative side and back towards zero.
      drain_pipeline();
      phase_no = RANDOM_PHASES;
      idle_pct = IDLE_PCT;
      program_controller('0, GAIN_W'(1), '0, SPEED_W'(WINDUP_BASE), '1);
      repeat (WINDUP_RISE) send_position(POS_W'($urandom_range(WINDUP_BAND)));
      repeat (WINDUP_FALL) begin
         send_position(POS_W'($urandom_range(POS_ALL_MAX, POS_ALL_MAX - WINDUP_BAND)));
      end
      repeat (WINDUP_RECOVER) send_position(POS_W'($urandom_range(WINDUP_BAND)));

      drain_pipeline();
      if (speeds_pending != 0) begin
         $display("%0t: %0d responses never arrived", $time, speeds_pending);
      end
      if (mismatch_count == 0 && speeds_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Guards against a hung handshake.
   initial begin
      #RUN_LIMIT;
      $display("TEST FAILED");
      $finish;
   end

endmodule
